/* rtl/gcpf_pkg.sv */
// gcpf_pkg: shared types, constants and opcode classification for the
// GPU command packet framer. No dependencies.
`timescale 1ns / 1ps

package gcpf_pkg;

	// Default limit on words in a poly-line packet
	localparam int MaxPacketWordsDef = 255;

	// Entries in the queue between front and back
	localparam int QueueDepth = 2;

	// Poly-line terminator match
	localparam logic [31:0] TERM_MASK  = 32'hF000F000;
	localparam logic [31:0] TERM_VALUE = 32'h50005000;

	// Item kind codes
	localparam logic KIND_WORD  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// How a packet length is decided
	typedef enum logic [1:0] {
		LK_NOP    = 2'd0,
		LK_FIXED  = 2'd1,
		LK_FLAT   = 2'd2,
		LK_SHADED = 2'd3
	} len_kind_t;

	// Properties of an opcode
	typedef struct packed {
		len_kind_t   lk;
		logic [3:0]  fixed_len;
		logic        draw;
		logic        rect;
		logic        irq;
	} op_class_t;

	// One classified item as it waits in the queue
	typedef struct packed {
		logic        kind;
		logic [31:0] word;
		logic        frame_skipped;
		op_class_t   cls;
		logic        term;
		logic [10:0] rw_cand;
		logic [9:0]  rh_cand;
	} item_t;

	// Lengths of polygon opcodes 20-3F, per group of four
	function automatic logic [3:0] poly_len(input logic [2:0] grp);
		logic [3:0] len;
		case (grp)
			3'd0: len = 4'd4;
			3'd1: len = 4'd7;
			3'd2: len = 4'd5;
			3'd3: len = 4'd9;
			3'd4: len = 4'd6;
			3'd5: len = 4'd9;
			3'd6: len = 4'd8;
			3'd7: len = 4'd12;
			default: len = 4'd4;
		endcase
		return len;
	endfunction

	// Lengths of rectangle opcodes 60-7F, per group of four
	function automatic logic [3:0] tile_len(input logic [2:0] grp);
		logic [3:0] len;
		case (grp)
			3'd0: len = 4'd3;
			3'd1: len = 4'd4;
			3'd2: len = 4'd2;
			3'd3: len = 4'd3;
			3'd4: len = 4'd2;
			3'd5: len = 4'd3;
			3'd6: len = 4'd2;
			3'd7: len = 4'd3;
			default: len = 4'd3;
		endcase
		return len;
	endfunction

	// Classify an opcode byte
	function automatic op_class_t classify(input logic [7:0] op);
		op_class_t c;
		c.lk        = LK_NOP;
		c.fixed_len = 4'd1;
		c.draw      = (op inside {[8'h20:8'h7F]});
		c.rect      = (op inside {[8'hA0:8'hBF]});
		c.irq       = (op == 8'h1F);
		if (op == 8'h01 || op == 8'h1F || (op inside {[8'hE1:8'hE6]})) begin
			c.lk = LK_FIXED;
			c.fixed_len = 4'd1;
		end else if (op == 8'h02) begin
			c.lk = LK_FIXED;
			c.fixed_len = 4'd3;
		end else if (op inside {[8'h20:8'h3F]}) begin
			c.lk = LK_FIXED;
			c.fixed_len = poly_len(op[4:2]);
		end else if (op inside {[8'h40:8'h47]}) begin
			c.lk = LK_FIXED;
			c.fixed_len = 4'd3;
		end else if (op inside {[8'h48:8'h4F]}) begin
			c.lk = LK_FLAT;
		end else if (op inside {[8'h50:8'h57]}) begin
			c.lk = LK_FIXED;
			c.fixed_len = 4'd4;
		end else if (op inside {[8'h58:8'h5F]}) begin
			c.lk = LK_SHADED;
		end else if (op inside {[8'h60:8'h7F]}) begin
			c.lk = LK_FIXED;
			c.fixed_len = tile_len(op[4:2]);
		end else if (op inside {[8'h80:8'h9F]}) begin
			c.lk = LK_FIXED;
			c.fixed_len = 4'd4;
		end else if (op inside {[8'hA0:8'hDF]}) begin
			c.lk = LK_FIXED;
			c.fixed_len = 4'd3;
		end
		return c;
	endfunction

endpackage

/* rtl/gpu_command_packet_framer_top.sv */
// An accepted item is written into the queue and moves on into the result
// register when that register is empty or being taken. Throughput: one item
// per cycle while results are taken; the back end retires one queued item a
// cycle, and a flush retires without producing a result.
// Reset (arst_n low, asynchronous) empties the queue, closes any open
// packet and drops any pending result.
`timescale 1ns / 1ps

module gpu_command_packet_framer_top #(
	parameter int MAX_PACKET_WORDS = gcpf_pkg::MaxPacketWordsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] word,
	input  logic        frame_skipped,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] echo_word,
	output logic [7:0]  command_id,
	output logic [7:0]  position,
	output logic        is_nop,
	output logic        last,
	output logic        execute,
	output logic [7:0]  packet_length,
	output logic [10:0] rect_width,
	output logic [9:0]  rect_height,
	output logic        irq_request
);
	import gcpf_pkg::*;

	item_t in_item;
	item_t head_item;
	logic  q_full;
	logic  head_valid;
	logic  pop;

	assign in_ready = !q_full;

	// Classify incoming items
	gcpf_front u_front (
		.kind          (kind),
		.word          (word),
		.frame_skipped (frame_skipped),
		.item          (in_item)
	);

	// Decouple front from back
	gcpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_item  (in_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Frame packets and hold results
	gcpf_back #(
		.MAX_PACKET_WORDS (MAX_PACKET_WORDS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.echo_word     (echo_word),
		.command_id    (command_id),
		.position      (position),
		.is_nop        (is_nop),
		.last          (last),
		.execute       (execute),
		.packet_length (packet_length),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.irq_request   (irq_request)
	);

endmodule

/* rtl/gcpf_front.sv */
// gcpf_front: classifies an incoming item before it enters the queue.
// Depends on gcpf_pkg.
`timescale 1ns / 1ps

module gcpf_front (
	input  logic            kind,
	input  logic [31:0]     word,
	input  logic            frame_skipped,
	output gcpf_pkg::item_t item
);
	import gcpf_pkg::*;

	logic [9:0] w_m1;
	logic [8:0] h_m1;

	// Precompute the write-rectangle size in case this is word 2
	assign w_m1 = word[9:0] - 10'd1;
	assign h_m1 = word[24:16] - 9'd1;

	// Build the classified item
	always_comb begin
		item.kind          = kind;
		item.word          = word;
		item.frame_skipped = frame_skipped;
		item.cls           = classify(word[31:24]);
		item.term          = ((word & TERM_MASK) == TERM_VALUE);
		item.rw_cand       = {1'b0, w_m1} + 11'd1;
		item.rh_cand       = {1'b0, h_m1} + 10'd1;
	end

endmodule

/* rtl/gcpf_queue.sv */
// gcpf_queue: short FIFO of classified items between front and back.
// Depends on gcpf_pkg.
`timescale 1ns / 1ps

module gcpf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gcpf_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output gcpf_pkg::item_t head_item
);
	import gcpf_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);
	localparam logic [PtrW-1:0] LastPtr  = PtrW'(QueueDepth - 1);

	item_t           mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == DepthCnt);
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthCnt)
		else $error("queue count beyond depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push && count_q == CntW'(1)) |=> !head_valid)
		else $error("queue not empty after last entry popped");

endmodule

/* rtl/gcpf_back.sv */
// gcpf_back: packet framing state and result register.
// Takes classified items from the queue. Depends on gcpf_pkg.
`timescale 1ns / 1ps

module gcpf_back #(
	parameter int MAX_PACKET_WORDS = gcpf_pkg::MaxPacketWordsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  gcpf_pkg::item_t head_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     echo_word,
	output logic [7:0]      command_id,
	output logic [7:0]      position,
	output logic            is_nop,
	output logic            last,
	output logic            execute,
	output logic [7:0]      packet_length,
	output logic [10:0]     rect_width,
	output logic [9:0]      rect_height,
	output logic            irq_request
);
	import gcpf_pkg::*;

	localparam logic [7:0] FlatEnd   = 8'(MAX_PACKET_WORDS - 2);
	localparam logic [7:0] ShadedEnd = 8'(MAX_PACKET_WORDS - 1);

	// Framing state
	logic [7:0]  words_held_q;
	logic [7:0]  open_op_q;
	op_class_t   open_cls_q;
	logic [10:0] held_w_q;
	logic [9:0]  held_h_q;

	// Result register
	logic        out_valid_q;
	logic [31:0] echo_q;
	logic [7:0]  op_q;
	logic [7:0]  pos_q;
	logic        nop_q;
	logic        last_q;
	logic        exec_q;
	logic [7:0]  plen_q;
	logic [10:0] rw_q;
	logic [9:0]  rh_q;
	logic        irq_q;

	// Per-word decision
	logic        first;
	logic [7:0]  op;
	op_class_t   cls;
	logic [7:0]  pos;
	logic [7:0]  pos_p1;
	logic [3:0]  len_m1;
	logic        last_w;
	logic        nop_w;
	logic        exec_w;
	logic        cap_rect;
	logic [10:0] rw_w;
	logic [9:0]  rh_w;
	logic        is_flush;
	logic        load;

	assign is_flush = (head_item.kind == KIND_FLUSH);
	assign pop      = head_valid && (is_flush || !out_valid_q || out_ready);
	assign load     = pop && !is_flush;

	// Pick the packet the word belongs to
	assign first  = (words_held_q == 8'd0);
	assign op     = first ? head_item.word[31:24] : open_op_q;
	assign cls    = first ? head_item.cls : open_cls_q;
	assign pos    = words_held_q;
	assign pos_p1 = pos + 8'd1;
	assign len_m1 = cls.fixed_len - 4'd1;

	// Decide whether this word ends the packet
	always_comb begin
		nop_w  = 1'b0;
		last_w = 1'b0;
		case (cls.lk)
			LK_NOP: begin
				nop_w  = 1'b1;
				last_w = 1'b1;
			end
			LK_FLAT: begin
				last_w = (pos >= 8'd3 && head_item.term) || (pos >= FlatEnd);
			end
			LK_SHADED: begin
				last_w = (pos >= 8'd4 && !pos[0] && head_item.term) || (pos >= ShadedEnd);
			end
			LK_FIXED: begin
				last_w = (pos >= {4'd0, len_m1});
			end
			default: begin
				last_w = 1'b1;
			end
		endcase
	end

	// Rectangle capture, and result fields that only mean something on the last word
	assign cap_rect = !nop_w && cls.rect && (pos == 8'd2);
	assign exec_w   = last_w && !nop_w && !(head_item.frame_skipped && cls.draw);
	assign rw_w     = (last_w && !nop_w && cls.rect) ?
		(cap_rect ? head_item.rw_cand : held_w_q) : 11'd0;
	assign rh_w     = (last_w && !nop_w && cls.rect) ?
		(cap_rect ? head_item.rh_cand : held_h_q) : 10'd0;

	// Update framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_held_q <= 8'd0;
			open_op_q    <= 8'd0;
			open_cls_q   <= '0;
			held_w_q     <= 11'd0;
			held_h_q     <= 10'd0;
		end else if (pop) begin
			if (is_flush) begin
				words_held_q <= 8'd0;
			end else begin
				if (cap_rect) begin
					held_w_q <= head_item.rw_cand;
					held_h_q <= head_item.rh_cand;
				end
				if (last_w) begin
					words_held_q <= 8'd0;
				end else begin
					words_held_q <= pos_p1;
					open_op_q    <= op;
					open_cls_q   <= cls;
				end
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			echo_q <= head_item.word;
			op_q   <= op;
			pos_q  <= pos;
			nop_q  <= nop_w;
			last_q <= last_w;
			exec_q <= exec_w;
			plen_q <= last_w ? (nop_w ? 8'd1 : pos_p1) : 8'd0;
			rw_q   <= rw_w;
			rh_q   <= rh_w;
			irq_q  <= exec_w && cls.irq;
		end
	end

	assign out_valid     = out_valid_q;
	assign echo_word     = echo_q;
	assign command_id    = op_q;
	assign position      = pos_q;
	assign is_nop        = nop_q;
	assign last          = last_q;
	assign execute       = exec_q;
	assign packet_length = plen_q;
	assign rect_width    = rw_q;
	assign rect_height   = rh_q;
	assign irq_request   = irq_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		words_held_q <= ShadedEnd)
		else $error("open packet longer than the limit");

	a_open_not_nop: assert property (@(posedge clk) disable iff (!arst_n)
		(words_held_q != 8'd0) |-> (open_cls_q.lk != LK_NOP))
		else $error("packet held open for a one-word opcode");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_w) |=> (words_held_q == 8'd0))
		else $error("packet still open after its last word");

endmodule
